FILE: hw/rtl/gbmp_pkg.sv
// ============================================================================
// gbmp_pkg
// Shared types, constants and helpers for the Goertzel bin magnitude/phase
// block.
// ============================================================================
package gbmp_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int ACC_W    = 48;             // recurrence accumulators
    localparam int WIDE_W   = 56;             // pre-saturation sums
    localparam int MULA_W   = 48;             // multiplier wide operand
    localparam int MULK_W   = 21;             // multiplier narrow operand
    localparam int PROD_W   = MULA_W + MULK_W;
    localparam int RND_W    = PROD_W - 16;    // product rounded to Q.8
    localparam int COEF_W   = 18;             // Q2.16 coefficients
    localparam int CW       = 44;             // CORDIC x/y width
    localparam int ZW       = 32;             // CORDIC angle, 2^-32 turns
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W   = 5;
    localparam int DIV_W    = 51;             // divider numerator/quotient
    localparam int SQ_W     = 42;             // sum of squares and root
    localparam int MAG_W    = 20;
    localparam int PH_W     = 16;
    localparam int M_TDATA_W = ((MAG_W + PH_W + 7) / 8) * 8;

    localparam int CFG_N_W  = 11;
    localparam int CFG_F_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CFG_N_W-1:0] SAMPLE_COUNT_RST = 11'd1024;
    localparam logic [CFG_F_W-1:0] FREQ_FRACTION_RST = 16'd4096;
    localparam logic REG_SAMPLE_COUNT  = 1'b0;
    localparam logic REG_FREQ_FRACTION = 1'b1;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 44'sd652032874;
    localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [MAG_W-1:0] MAG_SAT = '1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_LOAD, ST_MEAN_GO, ST_MEAN_WAIT, ST_SC_GO, ST_SC_WAIT, ST_COEF,
        ST_RD, ST_MUL, ST_ADD, ST_RE_MUL, ST_RE_ADD, ST_IM_ADD,
        ST_SRE_GO, ST_SRE_WAIT, ST_SIM_GO, ST_SIM_WAIT,
        ST_SQ_RE, ST_SQ_IM, ST_SQ_ADD, ST_SQRT, ST_NORM,
        ST_VEC_GO, ST_VEC_WAIT, ST_OUT
    } gbmp_state_t;

    typedef struct packed {
        logic start;
        logic vect;   // 1: vectoring (drive y to zero), 0: rotation
    } cordic_ctl_t;

    function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > WIDE_W'(ACC_MAX)) begin
            r = ACC_MAX;
        end else if (v < WIDE_W'(ACC_MIN)) begin
            r = ACC_MIN;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] abs48(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

endpackage

FILE: hw/rtl/goertzel_bin_magnitude_phase.sv
// ============================================================================
// goertzel_bin_magnitude_phase
// Single-bin Goertzel DFT: frame capture, mean removal, recurrence, and
// magnitude/phase of the bin through a shared multiplier, divider and CORDIC.
// ============================================================================
//
//  Channel   Direction  Signals                        Word
//  s_        in         s_tvalid/s_tready/s_tdata      one ADC sample
//  m_        out        m_tvalid/m_tready/m_tdata/user one bin result
//  APB       in/out     psel/penable/pwrite/paddr/...  sample_count, freq_fraction
//
//  Samples load one per cycle into the sample RAM. After the last sample of a
//  frame of N, the sequencer is busy with two scaling divisions plus one for
//  the mean, two 24-step CORDIC passes, the recurrence for each sample (RAM
//  read, multiply, add), and a 21-step square root. s_tready stays low
//  meanwhile. An invalid frame goes straight to the output. Reset is
//  synchronous, active low; the RAM needs no clearing.
//  A result waiting in the output register only stalls the next frame's end.
//
module goertzel_bin_magnitude_phase #(
    parameter int MAX_SAMPLES = gbmp_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = gbmp_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [SAMPLE_BITS-1:0] sample
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,
    // m_tdata: [19:0] magnitude, [35:20] phase; m_tuser: [0] valid_res
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gbmp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbmp_pkg::APB_AW-1:0]      paddr,
    input  logic [gbmp_pkg::APB_DW-1:0]      pwdata,
    output logic [gbmp_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import gbmp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int MEAN_W = SAMPLE_BITS + 8;
    localparam int X_W    = SAMPLE_BITS + 9;
    localparam int DEN_W  = CNT_W + 1;
    localparam int LEN_W  = (CNT_W > CFG_N_W) ? CNT_W : CFG_N_W;

    // ---------------- configuration registers ----------------
    logic [CFG_N_W-1:0] sample_count_reg;
    logic [CFG_F_W-1:0] freq_fraction_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg  <= SAMPLE_COUNT_RST;
            freq_fraction_reg <= FREQ_FRACTION_RST;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_SAMPLE_COUNT:  sample_count_reg  <= pwdata[CFG_N_W-1:0];
                REG_FREQ_FRACTION: freq_fraction_reg <= pwdata[CFG_F_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SAMPLE_COUNT:  prdata = APB_DW'(sample_count_reg);
            REG_FREQ_FRACTION: prdata = APB_DW'(freq_fraction_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- state and datapath registers ----------------
    gbmp_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, idx_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [MEAN_W-1:0]        mean_reg;
    logic                     ok_reg, flip_reg;
    logic signed [COEF_W-1:0] c_reg, s_reg, coeff_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [ACC_W-1:0]  prev_reg, prev2_reg, re_reg, im_reg, nx_reg, ny_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          sq_reg, root_reg;
    logic [SQ_W-2:0]          bit_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [PH_W-1:0]          phase_reg;
    logic                     m_tvalid_reg, m_tuser_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    // ---------------- input side ----------------
    logic [SAMPLE_BITS-1:0] smp;
    logic                   s_fire, frame_end, cfg_ok;
    logic [CNT_W-1:0]       cnt_inc;
    logic [LEN_W-1:0]       len;

    assign smp     = s_tdata[SAMPLE_BITS-1:0];
    assign s_fire  = s_tvalid && s_tready;
    assign cnt_inc = cnt_reg + 1'b1;

    // clamp the frame length to [1, MAX_SAMPLES]
    always_comb begin
        priority if (sample_count_reg == '0) begin
            len = LEN_W'(1);
        end else if (LEN_W'(sample_count_reg) > LEN_W'(MAX_SAMPLES)) begin
            len = LEN_W'(MAX_SAMPLES);
        end else begin
            len = LEN_W'(sample_count_reg);
        end
    end

    assign frame_end = LEN_W'(cnt_inc) >= len;
    assign cfg_ok    = (cnt_inc >= CNT_W'(3)) && (freq_fraction_reg != '0)
                     && !freq_fraction_reg[CFG_F_W-1];

    // ---------------- sample RAM ----------------
    logic [SAMPLE_BITS-1:0] ram_rdata;

    gbmp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (smp),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- shared divider ----------------
    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic [ACC_W-1:0] abs_re, abs_im;

    assign abs_re  = abs48(re_reg);
    assign abs_im  = abs48(im_reg);
    assign div_den = {cnt_reg, 1'b0};

    gbmp_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .busy    (div_busy)
    );

    // ---------------- shared CORDIC ----------------
    cordic_ctl_t          cor_ctl;
    logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
    logic [ZW-1:0]        cor_z0, cor_z;
    logic                 cor_busy;

    gbmp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cor_ctl),
        .x0      (cor_x0),
        .y0      (cor_y0),
        .z0      (cor_z0),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z),
        .busy    (cor_busy)
    );

    // ---------------- shared multiplier ----------------
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULK_W-1:0] mul_k;
    logic signed [PROD_W-1:0] prod_bias;
    logic signed [RND_W-1:0]  rnd;

    // round half up to Q.8: (a*k + 2^15) >>> 16
    assign prod_bias = prod_reg + PROD_W'(32768);
    assign rnd       = $signed(prod_bias[PROD_W-1:16]);

    // ---------------- derived values ----------------
    logic [CFG_F_W-1:0]       fold;
    logic signed [CW-1:0]     cx_b, cy_b;
    logic signed [COEF_W-1:0] c_w, s_w, coeff_w;
    logic signed [COEF_W:0]   c2;
    logic signed [WIDE_W-1:0] recur_sum, re_sum;
    logic                     mag_big, zero_vec, norm_big, norm_small;
    logic [ACC_W-1:0]         abs_nx, abs_ny;
    logic signed [ACC_W-1:0]  vx, vy;
    logic [SQ_W-1:0]          trial;
    logic [ZW-1:0]            z_rnd;

    // fold angles above a quarter turn back and negate cosine later
    assign fold = (freq_fraction_reg > CFG_F_W'(16384))
                ? CFG_F_W'(32768) - freq_fraction_reg : freq_fraction_reg;

    assign cx_b    = cor_x + CW'(8192);
    assign cy_b    = cor_y + CW'(8192);
    assign c_w     = flip_reg ? -$signed(cx_b[COEF_W+13:14]) : $signed(cx_b[COEF_W+13:14]);
    assign s_w     = $signed(cy_b[COEF_W+13:14]);
    assign c2      = {c_w, 1'b0};
    assign coeff_w = (c2 > (COEF_W+1)'(131071))  ? COEF_W'(131071)
                   : (c2 < -(COEF_W+1)'(131072)) ? -COEF_W'(131072) : c2[COEF_W-1:0];

    assign recur_sum = WIDE_W'(x_reg) + WIDE_W'(rnd) - WIDE_W'(prev2_reg);
    assign re_sum    = WIDE_W'(prev_reg) - WIDE_W'(rnd);

    assign mag_big  = (abs_re >= ACC_W'(1 << MAG_W)) || (abs_im >= ACC_W'(1 << MAG_W));
    assign trial    = root_reg + SQ_W'(bit_reg);

    assign abs_nx     = abs48(nx_reg);
    assign abs_ny     = abs48(ny_reg);
    assign zero_vec   = (nx_reg == '0) && (ny_reg == '0);
    assign norm_big   = (abs_nx >= ACC_W'(64'd1 << 40)) || (abs_ny >= ACC_W'(64'd1 << 40));
    assign norm_small = (abs_nx <  ACC_W'(64'd1 << 38)) && (abs_ny <  ACC_W'(64'd1 << 38));
    assign vx         = nx_reg[ACC_W-1] ? -nx_reg : nx_reg;
    assign vy         = nx_reg[ACC_W-1] ? -ny_reg : ny_reg;
    assign z_rnd      = cor_z + ZW'(32'h8000);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && frame_end) begin
                    state_next = cfg_ok ? ST_MEAN_GO : ST_OUT;
                end
            end
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (!div_busy) state_next = ST_SC_GO;
            ST_SC_GO:     state_next = ST_SC_WAIT;
            ST_SC_WAIT:   if (!cor_busy) state_next = ST_COEF;
            ST_COEF:      state_next = ST_RD;
            ST_RD:        state_next = ST_MUL;
            ST_MUL:       state_next = ST_ADD;
            ST_ADD:       state_next = (idx_reg + 1'b1 == cnt_reg) ? ST_RE_MUL : ST_RD;
            ST_RE_MUL:    state_next = ST_RE_ADD;
            ST_RE_ADD:    state_next = ST_IM_ADD;
            ST_IM_ADD:    state_next = ST_SRE_GO;
            ST_SRE_GO:    state_next = ST_SRE_WAIT;
            ST_SRE_WAIT:  if (!div_busy) state_next = ST_SIM_GO;
            ST_SIM_GO:    state_next = ST_SIM_WAIT;
            ST_SIM_WAIT:  if (!div_busy) state_next = ST_SQ_RE;
            ST_SQ_RE:     state_next = mag_big ? ST_NORM : ST_SQ_IM;
            ST_SQ_IM:     state_next = ST_SQ_ADD;
            ST_SQ_ADD:    state_next = ST_SQRT;
            ST_SQRT:      if (bit_reg == '0) state_next = ST_NORM;
            ST_NORM: begin
                if (zero_vec) begin
                    state_next = ST_OUT;
                end else if (!norm_big && !norm_small) begin
                    state_next = ST_VEC_GO;
                end
            end
            ST_VEC_GO:    state_next = ST_VEC_WAIT;
            ST_VEC_WAIT:  if (!cor_busy) state_next = ST_OUT;
            ST_OUT:       if (!m_tvalid_reg || m_tready) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // ---------------- sequencer: unit controls ----------------
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        cor_ctl   = '0;
        cor_x0    = '0;
        cor_y0    = '0;
        cor_z0    = '0;
        mul_a     = '0;
        mul_k     = '0;
        unique case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_MEAN_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'({sum_reg, 9'b0}) + DIV_W'(cnt_reg);
            end
            ST_SC_GO: begin
                cor_ctl.start = 1'b1;
                cor_x0        = CORDIC_GAIN;
                cor_z0        = {fold, 16'b0};
            end
            ST_MUL: begin
                mul_a = prev_reg;
                mul_k = MULK_W'(coeff_reg);
            end
            ST_RE_MUL: begin
                mul_a = prev2_reg;
                mul_k = MULK_W'(c_reg);
            end
            ST_RE_ADD: begin
                mul_a = prev2_reg;
                mul_k = MULK_W'(s_reg);
            end
            ST_SRE_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'({abs_re, 2'b0}) + DIV_W'(cnt_reg);
            end
            ST_SIM_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'({abs_im, 2'b0}) + DIV_W'(cnt_reg);
            end
            ST_SQ_RE: begin
                mul_a = $signed(abs_re);
                mul_k = $signed(abs_re[MULK_W-1:0]);
            end
            ST_SQ_IM: begin
                mul_a = $signed(abs_im);
                mul_k = $signed(abs_im[MULK_W-1:0]);
            end
            ST_VEC_GO: begin
                cor_ctl.start = 1'b1;
                cor_ctl.vect  = 1'b1;
                cor_x0        = CW'(vx);
                cor_y0        = CW'(vy);
                cor_z0        = nx_reg[ACC_W-1] ? HALF_TURN : '0;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                cnt_reg <= cnt_inc;
                sum_reg <= sum_reg + SUM_W'(smp);
            end
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                // hand the result over and open the next frame
                m_tvalid_reg <= 1'b1;
                cnt_reg      <= '0;
                sum_reg      <= '0;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_k;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && frame_end) begin
                    ok_reg    <= cfg_ok;
                    mag_reg   <= '0;
                    phase_reg <= '0;
                end
            end
            ST_MEAN_GO: begin
                prev_reg  <= '0;
                prev2_reg <= '0;
                idx_reg   <= '0;
            end
            ST_MEAN_WAIT: mean_reg <= div_quo[MEAN_W-1:0];
            ST_SC_GO:     flip_reg <= freq_fraction_reg > CFG_F_W'(16384);
            ST_COEF: begin
                c_reg     <= c_w;
                s_reg     <= s_w;
                coeff_reg <= coeff_w;
            end
            ST_MUL: x_reg <= $signed({1'b0, ram_rdata, 8'b0}) - $signed({1'b0, mean_reg});
            ST_ADD: begin
                prev2_reg <= prev_reg;
                prev_reg  <= sat48(recur_sum);
                idx_reg   <= idx_reg + 1'b1;
            end
            ST_RE_ADD: re_reg <= sat48(re_sum);
            ST_IM_ADD: im_reg <= sat48(WIDE_W'(rnd));
            ST_SRE_WAIT: begin
                if (!div_busy) begin
                    re_reg <= re_reg[ACC_W-1] ? -$signed(div_quo[ACC_W-1:0])
                                              : $signed(div_quo[ACC_W-1:0]);
                end
            end
            ST_SIM_WAIT: begin
                if (!div_busy) begin
                    im_reg <= im_reg[ACC_W-1] ? -$signed(div_quo[ACC_W-1:0])
                                              : $signed(div_quo[ACC_W-1:0]);
                end
            end
            ST_SQ_RE: begin
                nx_reg <= re_reg;
                ny_reg <= im_reg;
                if (mag_big) begin
                    mag_reg <= MAG_SAT;
                end
            end
            ST_SQ_IM: sq_reg <= SQ_W'(prod_reg);
            ST_SQ_ADD: begin
                sq_reg   <= sq_reg + SQ_W'(prod_reg);
                root_reg <= '0;
                bit_reg  <= {1'b1, {(SQ_W-2){1'b0}}};
            end
            ST_SQRT: begin
                if (bit_reg == '0) begin
                    // round to nearest, then clip to the output range
                    if (sq_reg > root_reg) begin
                        mag_reg <= (root_reg + 1'b1 > SQ_W'(MAG_SAT)) ? MAG_SAT
                                 : MAG_W'(root_reg + 1'b1);
                    end else begin
                        mag_reg <= (root_reg > SQ_W'(MAG_SAT)) ? MAG_SAT : MAG_W'(root_reg);
                    end
                end else begin
                    if (sq_reg >= trial) begin
                        sq_reg   <= sq_reg - trial;
                        root_reg <= (root_reg >> 1) + SQ_W'(bit_reg);
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_NORM: begin
                // bring the vector into [2^38, 2^40) before vectoring
                if (!zero_vec) begin
                    if (norm_big) begin
                        nx_reg <= nx_reg >>> 1;
                        ny_reg <= ny_reg >>> 1;
                    end else if (norm_small) begin
                        nx_reg <= nx_reg <<< 1;
                        ny_reg <= ny_reg <<< 1;
                    end
                end
            end
            ST_VEC_WAIT: if (!cor_busy) phase_reg <= z_rnd[ZW-1:ZW-PH_W];
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= M_TDATA_W'({phase_reg, mag_reg});
                    m_tuser_reg <= ok_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("invalid result carries nonzero data");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cnt_reg < CNT_W'(MAX_SAMPLES)))
        else $error("sample counter overruns the store");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |-> (idx_reg < cnt_reg))
        else $error("recurrence reads past the frame");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_cordic_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_ctl.start |=> cor_busy)
        else $error("CORDIC failed to start");

endmodule

FILE: hw/rtl/gbmp_ram.sv
// ============================================================================
// gbmp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module gbmp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/gbmp_div.sv
// ============================================================================
// gbmp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module gbmp_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             busy
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            // shift quotient bits in where numerator bits leave
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
        end
    end

    assign quo  = num_reg;
    assign busy = busy_reg;
endmodule

FILE: hw/rtl/gbmp_cordic.sv
// ============================================================================
// gbmp_cordic
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// ============================================================================
module gbmp_cordic (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gbmp_pkg::cordic_ctl_t        ctl,
    input  logic signed [gbmp_pkg::CW-1:0] x0,
    input  logic signed [gbmp_pkg::CW-1:0] y0,
    input  logic [gbmp_pkg::ZW-1:0]      z0,
    output logic signed [gbmp_pkg::CW-1:0] x_out,
    output logic signed [gbmp_pkg::CW-1:0] y_out,
    output logic [gbmp_pkg::ZW-1:0]      z_out,
    output logic                         busy
);
    import gbmp_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, dx, dy;
    logic [ZW-1:0]        z_reg, at;
    logic [STEP_W-1:0]    i_reg;
    logic                 vect_reg, busy_reg, sub;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = atan_turn(i_reg);
    // rotation follows the sign of z, vectoring the sign of y
    assign sub = vect_reg ? !(y_reg > 0) : !z_reg[ZW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            i_reg    <= '0;
        end else if (busy_reg) begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            vect_reg <= ctl.vect;
        end else if (busy_reg) begin
            if (sub) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign busy  = busy_reg;
endmodule
